[sv/oahs_pkg.sv]
// Package for the open addressing hash set: widths, codes, payload structs,
// controller state type and the command/status structs. No dependencies.
`timescale 1ns / 1ps
package oahs_pkg;
  localparam int SLOTS = 256;
  localparam int KEY_BITS = 32;
  localparam int HASH_BITS = 32;
  localparam int IDX_BITS = $clog2(SLOTS);
  localparam int CNT_BITS = IDX_BITS + 1;
  localparam int PROBE_LIMIT = SLOTS + 64;
  localparam int PCNT_BITS = $clog2(PROBE_LIMIT + 1);
  localparam int FILL_LIMIT = (SLOTS - 1) * 3;

  localparam logic [1:0] TAG_UNUSED = 2'd0;
  localparam logic [1:0] TAG_ACTIVE = 2'd1;
  localparam logic [1:0] TAG_DELETED = 2'd2;

  localparam logic [1:0] OP_ADD = 2'd0;
  localparam logic [1:0] OP_CONTAINS = 2'd1;
  localparam logic [1:0] OP_DISCARD = 2'd2;
  localparam logic [1:0] OP_POP = 2'd3;

  localparam logic [2:0] ST_DONE = 3'd0;
  localparam logic [2:0] ST_PRESENT = 3'd1;
  localparam logic [2:0] ST_NOT_FOUND = 3'd2;
  localparam logic [2:0] ST_EMPTY = 3'd3;
  localparam logic [2:0] ST_FULL = 3'd4;

  typedef struct packed {
    logic [1:0]           op;
    logic [KEY_BITS-1:0]  key_value;
    logic [HASH_BITS-1:0] hash_value;
  } in_item_t;

  typedef struct packed {
    logic [2:0]          status;
    logic [KEY_BITS-1:0] popped_key;
    logic [CNT_BITS-1:0] element_total;
  } out_item_t;

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_READ, S_EVAL, S_WRITE, S_DONE
  } ctl_state_t;

  // controller -> datapath
  typedef struct packed {
    logic clear;  // clear one slot tag
    logic load;   // capture request, start probe/scan
    logic rd;     // issue slot read
    logic eval;   // evaluate slot read data
    logic commit; // apply the outcome, form result
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic finished;   // evaluation reached an outcome
    logic clear_last; // clearing pass is at the last slot
  } dp_sts_t;
endpackage

[sv/open_addressing_hash_set.sv]
// Top level of the open addressing hash set engine.
// Depends on oahs_pkg, oahs_ctrl, oahs_dp (and oahs_ram through it).
`timescale 1ns / 1ps
// A request passes through the read, evaluate and write states to its
// result. Evaluation goes on while further slots are visited: one slot read
// per cycle through the tag/key/hash RAM ports. Pop walks from the finger one
// slot a cycle until it meets an active slot.
// The result is held until taken; the next transaction is accepted in the
// cycle its result leaves. After reset a clearing pass marks every slot tag
// unused; the input stalls until it ends.
module open_addressing_hash_set (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  oahs_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output oahs_pkg::out_item_t out_data
);
  oahs_pkg::dp_cmd_t cmd;
  oahs_pkg::dp_sts_t sts;

  // sequence one transaction at a time
  oahs_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .cmd(cmd), .sts(sts));

  // probe, update and hold the result
  oahs_dp u_dp (
    .clk(clk), .rst_n(rst_n), .in_data(in_data), .cmd(cmd), .sts(sts),
    .out_data(out_data));
endmodule

[sv/oahs_ram.sv]
// Generic single-port RAM with registered read. No dependencies.
`timescale 1ns / 1ps
module oahs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[addr] <= wdata;
    end
    rdata <= mem_r[addr];
  end
endmodule

[sv/oahs_ctrl.sv]
// Controller state machine for the hash set: clearing pass, then read, evaluate, write.
// Depends on oahs_pkg.
`timescale 1ns / 1ps
module oahs_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  output logic             out_valid,
  input  logic             out_stall,
  output oahs_pkg::dp_cmd_t cmd,
  input  oahs_pkg::dp_sts_t sts
);
  oahs_pkg::ctl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= oahs_pkg::S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      oahs_pkg::S_CLEAR: state_nxt = sts.clear_last ? oahs_pkg::S_IDLE : oahs_pkg::S_CLEAR;
      oahs_pkg::S_IDLE:  if (in_valid) state_nxt = oahs_pkg::S_READ;
      oahs_pkg::S_READ:  state_nxt = oahs_pkg::S_EVAL;
      oahs_pkg::S_EVAL:  state_nxt = sts.finished ? oahs_pkg::S_WRITE : oahs_pkg::S_EVAL;
      oahs_pkg::S_WRITE: state_nxt = oahs_pkg::S_DONE;
      oahs_pkg::S_DONE: begin
        if (!out_stall) begin
          state_nxt = in_valid ? oahs_pkg::S_READ : oahs_pkg::S_IDLE;
        end
      end
      default: state_nxt = oahs_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_stall = 1'b1;
    out_valid = 1'b0;
    case (state_r)
      oahs_pkg::S_CLEAR: cmd.clear = 1'b1;
      oahs_pkg::S_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
      end
      oahs_pkg::S_READ: cmd.rd = 1'b1;
      oahs_pkg::S_EVAL: begin
        cmd.eval = 1'b1;
        cmd.rd = !sts.finished;
      end
      oahs_pkg::S_WRITE: cmd.commit = 1'b1;
      oahs_pkg::S_DONE: begin
        out_valid = 1'b1;
        in_stall = out_stall;
        cmd.load = !out_stall && in_valid;
      end
      default: ;
    endcase
  end
endmodule

[sv/oahs_dp.sv]
// Datapath for the hash set: slot stores, probe walker, counters, result.
// Depends on oahs_pkg and oahs_ram.
`timescale 1ns / 1ps
module oahs_dp (
  input  logic                  clk,
  input  logic                  rst_n,
  input  oahs_pkg::in_item_t    in_data,
  input  oahs_pkg::dp_cmd_t     cmd,
  output oahs_pkg::dp_sts_t     sts,
  output oahs_pkg::out_item_t   out_data
);
  localparam int IB = oahs_pkg::IDX_BITS;
  localparam int CB = oahs_pkg::CNT_BITS;
  localparam int PB = oahs_pkg::PCNT_BITS;
  localparam int KB = oahs_pkg::KEY_BITS;
  localparam int HB = oahs_pkg::HASH_BITS;

  oahs_pkg::in_item_t req_r;
  logic [HB-1:0] perturb_r;
  logic [IB-1:0] idx_r, ridx_r, at_r, free_r;
  logic          have_free_r, match_r, unused_r;
  logic [PB-1:0] pcnt_r;
  logic [CB-1:0] active_r, used_r;
  logic [IB-1:0] finger_r;
  logic [IB-1:0] clr_r;
  oahs_pkg::out_item_t res_r;
  logic          fin, hit, empty_pop;

  // Tags, keys and hashes all live in RAM; tags are cleared by a pass after reset.
  logic [1:0] tag_rd;

  logic          we;
  logic [IB-1:0] waddr, raddr, paddr;
  logic [KB-1:0] key_q;
  logic [HB-1:0] hash_q;
  logic          is_pop;
  assign is_pop = (req_r.op == oahs_pkg::OP_POP);

  logic [IB-1:0] nstep;
  logic [HB-1:0] pshift;
  assign pshift = perturb_r >> 5;
  assign nstep = is_pop ? idx_r + 1'b1
                        : IB'(({idx_r, 2'b00} + {2'b00, idx_r}) + 1'b1 + pshift[IB-1:0]);
  // read the next slot while the current one is evaluated
  assign paddr = (cmd.eval && !fin) ? nstep : idx_r;

  // Add new-slot write of key and hash happens in commit.
  logic          add_new, add_free, do_add, do_del;
  assign add_free = !match_r && have_free_r;
  assign add_new  = !match_r && !have_free_r && unused_r &&
                    ((32'(used_r) * 5) < oahs_pkg::FILL_LIMIT);
  assign do_add = cmd.commit && req_r.op == oahs_pkg::OP_ADD && (add_free || add_new);
  assign do_del = cmd.commit && match_r && (req_r.op == oahs_pkg::OP_DISCARD || is_pop);
  assign we = do_add;
  assign waddr = add_free ? free_r : at_r;
  assign raddr = we ? waddr : paddr;

  logic          tag_we;
  logic [IB-1:0] tag_addr, tag_waddr;
  logic [1:0]    tag_wdata;
  assign tag_we    = cmd.clear || do_add || do_del;
  assign tag_waddr = do_add ? waddr : at_r;
  assign tag_addr  = cmd.clear ? clr_r : (tag_we ? tag_waddr : paddr);
  assign tag_wdata = cmd.clear ? oahs_pkg::TAG_UNUSED
                   : (do_add ? oahs_pkg::TAG_ACTIVE : oahs_pkg::TAG_DELETED);

  oahs_ram #(.WIDTH(2), .DEPTH(oahs_pkg::SLOTS)) u_tag (
    .clk(clk), .we(tag_we), .addr(tag_addr), .wdata(tag_wdata), .rdata(tag_rd));
  oahs_ram #(.WIDTH(KB), .DEPTH(oahs_pkg::SLOTS)) u_key (
    .clk(clk), .we(we), .addr(raddr), .wdata(req_r.key_value), .rdata(key_q));
  oahs_ram #(.WIDTH(HB), .DEPTH(oahs_pkg::SLOTS)) u_hash (
    .clk(clk), .we(we), .addr(raddr), .wdata(req_r.hash_value), .rdata(hash_q));

  // Clearing pass over the tags after reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r <= '0;
    end else if (cmd.clear) begin
      clr_r <= clr_r + 1'b1;
    end
  end
  assign sts.clear_last = (clr_r == '1);

  // Evaluate the slot read last cycle.
  always_comb begin
    fin = 1'b0;
    hit = 1'b0;
    empty_pop = is_pop && active_r == '0;
    if (empty_pop) begin
      fin = 1'b1;
    end else if (is_pop) begin
      hit = tag_rd == oahs_pkg::TAG_ACTIVE;
      fin = hit;
    end else begin
      hit = tag_rd == oahs_pkg::TAG_ACTIVE && hash_q == req_r.hash_value &&
            key_q == req_r.key_value;
      fin = hit || tag_rd == oahs_pkg::TAG_UNUSED || pcnt_r == PB'(oahs_pkg::PROBE_LIMIT - 1);
    end
  end
  assign sts.finished = fin;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r <= in_data;
      perturb_r <= in_data.hash_value;
      idx_r <= (in_data.op == oahs_pkg::OP_POP) ? finger_r : in_data.hash_value[IB-1:0];
      pcnt_r <= '0;
      have_free_r <= 1'b0;
      match_r <= 1'b0;
      unused_r <= 1'b0;
    end else if (cmd.rd && !cmd.eval) begin
      ridx_r <= idx_r;
    end else if (cmd.eval) begin
      if (!is_pop && tag_rd == oahs_pkg::TAG_DELETED) begin
        have_free_r <= 1'b1;
        free_r <= ridx_r;
      end
      if (fin) begin
        match_r <= hit;
        unused_r <= tag_rd == oahs_pkg::TAG_UNUSED;
        at_r <= ridx_r;
        if (empty_pop) match_r <= 1'b0;
      end else begin
        perturb_r <= pshift;
        idx_r <= nstep;
        ridx_r <= nstep;
        pcnt_r <= pcnt_r + 1'b1;
      end
    end
  end

  // Counters and result.
  logic [IB-1:0] dslot;
  assign dslot = at_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= '0;
      used_r <= '0;
      finger_r <= '0;
    end else if (cmd.commit) begin
      case (req_r.op)
        oahs_pkg::OP_ADD: begin
          if (!match_r && add_free) begin
            active_r <= active_r + 1'b1;
          end else if (add_new) begin
            active_r <= active_r + 1'b1;
            used_r <= used_r + 1'b1;
          end
        end
        oahs_pkg::OP_DISCARD, oahs_pkg::OP_POP: begin
          if (match_r) begin
            active_r <= active_r - 1'b1;
            if (is_pop) finger_r <= dslot + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // Result is built at commit; key_q still holds the popped slot's key.
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      res_r.popped_key <= '0;
      res_r.element_total <= active_r;
      case (req_r.op)
        oahs_pkg::OP_ADD: begin
          if (match_r) res_r.status <= oahs_pkg::ST_PRESENT;
          else if (add_free || add_new) begin
            res_r.status <= oahs_pkg::ST_DONE;
            res_r.element_total <= active_r + 1'b1;
          end else res_r.status <= oahs_pkg::ST_FULL;
        end
        oahs_pkg::OP_CONTAINS:
          res_r.status <= match_r ? oahs_pkg::ST_DONE : oahs_pkg::ST_NOT_FOUND;
        oahs_pkg::OP_DISCARD: begin
          res_r.status <= match_r ? oahs_pkg::ST_DONE : oahs_pkg::ST_NOT_FOUND;
          if (match_r) res_r.element_total <= active_r - 1'b1;
        end
        oahs_pkg::OP_POP: begin
          res_r.status <= match_r ? oahs_pkg::ST_DONE : oahs_pkg::ST_EMPTY;
          if (match_r) begin
            res_r.popped_key <= key_q;
            res_r.element_total <= active_r - 1'b1;
          end
        end
        default: res_r.status <= oahs_pkg::ST_DONE;
      endcase
    end
  end
  assign out_data = res_r;
endmodule

[tb/testbench.sv]
// Testbench for the open addressing hash set engine: directed and random
// request streams checked against a behavioural model of the set.
// Depends on oahs_pkg and open_addressing_hash_set.
`timescale 1ns / 1ps
module testbench;
  import oahs_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam logic [8:0] SLOT_MASK = 9'(SLOTS - 1);

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_data;

  // model state of the set
  logic [1:0]          mdl_tag [SLOTS];
  logic [KEY_BITS-1:0] mdl_key [SLOTS];
  logic [HASH_BITS-1:0] mdl_hash [SLOTS];
  int unsigned         mdl_active;
  int unsigned         mdl_used;
  int unsigned         mdl_finger;

  out_item_t expected_results [$];
  int        error_count;
  bit        send_idling;
  bit        recv_idling;
  int        hold_off_cycles;
  int        quiet_cycles;

  // keys added so far (up to 400), reused to give hits
  logic [KEY_BITS-1:0]  known_keys [$];
  logic [HASH_BITS-1:0] known_hashes [$];

  open_addressing_hash_set dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Walk the probe path of one key; report a match, the terminal unused slot
  // and the last deleted slot met on the way.
  task automatic probe_slots(input logic [KEY_BITS-1:0] k, input logic [HASH_BITS-1:0] h,
                             output bit match, output bit hit_unused, output bit have_free,
                             output int at, output int free_at);
    logic [HASH_BITS-1:0] perturb;
    logic [63:0] idx;
    int s;
    match = 0; hit_unused = 0; have_free = 0; at = 0; free_at = 0;
    perturb = h;
    idx = 64'(h & HASH_BITS'(SLOT_MASK));
    for (int n = 0; n < PROBE_LIMIT; n++) begin
      s = int'(idx & 64'(SLOT_MASK));
      if (mdl_tag[s] == TAG_UNUSED) begin
        hit_unused = 1; at = s;
        return;
      end
      if (mdl_tag[s] == TAG_ACTIVE) begin
        if (mdl_hash[s] == h && mdl_key[s] == k) begin
          match = 1; at = s;
          return;
        end
      end else begin
        have_free = 1; free_at = s;
      end
      perturb = perturb >> 5;
      idx = (idx * 5 + 1 + 64'(perturb)) & 64'(SLOT_MASK);
    end
  endtask

  // Apply one request to the model and queue the result it should give.
  task automatic predict_request(input in_item_t req);
    out_item_t res;
    bit m, hu, hf;
    int at, fa, s;
    res = '0;
    res.status = ST_DONE;
    case (req.op)
      OP_ADD: begin
        probe_slots(req.key_value, req.hash_value, m, hu, hf, at, fa);
        if (m) res.status = ST_PRESENT;
        else if (hf) begin
          mdl_tag[fa] = TAG_ACTIVE; mdl_key[fa] = req.key_value;
          mdl_hash[fa] = req.hash_value; mdl_active++;
        end else if (hu && mdl_used * 5 < int'(SLOT_MASK) * 3) begin
          mdl_tag[at] = TAG_ACTIVE; mdl_key[at] = req.key_value;
          mdl_hash[at] = req.hash_value; mdl_active++; mdl_used++;
        end else res.status = ST_FULL;
      end
      OP_CONTAINS: begin
        probe_slots(req.key_value, req.hash_value, m, hu, hf, at, fa);
        if (!m) res.status = ST_NOT_FOUND;
      end
      OP_DISCARD: begin
        probe_slots(req.key_value, req.hash_value, m, hu, hf, at, fa);
        if (m) begin
          mdl_tag[at] = TAG_DELETED; mdl_active--;
        end else res.status = ST_NOT_FOUND;
      end
      default: begin
        if (mdl_active == 0) res.status = ST_EMPTY;
        else begin
          s = mdl_finger;
          for (int n = 0; n < SLOTS; n++) begin
            if (mdl_tag[s] == TAG_ACTIVE) break;
            s = (s + 1) % SLOTS;
          end
          if (mdl_tag[s] == TAG_ACTIVE) begin
            res.popped_key = mdl_key[s];
            mdl_tag[s] = TAG_DELETED; mdl_active--;
            mdl_finger = (s + 1) % SLOTS;
          end else res.status = ST_EMPTY;
        end
      end
    endcase
    res.element_total = CNT_BITS'(mdl_active);
    expected_results.push_back(res);
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %0h, expected %0h", what, got, want);
    error_count++;
  endtask

  // Offer one transaction, hold it until accepted, then predict it.
  task automatic send_request(input logic [1:0] op, input logic [KEY_BITS-1:0] k,
                              input logic [HASH_BITS-1:0] h);
    in_item_t req;
    req.op = op; req.key_value = k; req.hash_value = h;
    if (send_idling && $urandom_range(3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_request(req);
    if (op == OP_ADD && known_keys.size() < 400) begin
      known_keys.push_back(k); known_hashes.push_back(h);
    end
  endtask

  task automatic drain_results();
    if (in_valid) begin
      in_valid <= 1'b0;
    end
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  // Pick an earlier key half of the time so that hits happen.
  task automatic random_request(input int add_weight);
    logic [KEY_BITS-1:0] k;
    logic [HASH_BITS-1:0] h;
    logic [1:0] op;
    int r, j;
    r = $urandom_range(99);
    if (r < add_weight) op = OP_ADD;
    else if (r < add_weight + 25) op = OP_CONTAINS;
    else if (r < add_weight + 50) op = OP_DISCARD;
    else op = OP_POP;
    if (known_keys.size() != 0 && $urandom_range(1) == 0) begin
      j = $urandom_range(known_keys.size() - 1);
      k = known_keys[j]; h = known_hashes[j];
      // same key under another hash, or a hash collision with another key
      if ($urandom_range(15) == 0) h = $urandom();
      else if ($urandom_range(15) == 0) k = $urandom();
    end else begin
      k = $urandom();
      h = ($urandom_range(3) == 0) ? $urandom_range(15) : $urandom();
    end
    send_request(op, k, h);
  endtask

  task automatic test_directed();
    send_request(OP_POP, '0, '0);             // pop on an empty set
    send_request(OP_CONTAINS, '1, '1);
    send_request(OP_DISCARD, '0, '0);
    send_request(OP_ADD, '0, '0);
    send_request(OP_ADD, '1, '1);
    send_request(OP_ADD, '0, '0);             // already present
    send_request(OP_ADD, 32'h1, '0);          // same hash, other key
    send_request(OP_ADD, '0, 32'h100);        // same key, other hash
    send_request(OP_CONTAINS, '0, '0);
    send_request(OP_CONTAINS, '0, 32'h1);
    send_request(OP_DISCARD, '0, '0);
    send_request(OP_CONTAINS, 32'h1, '0);     // probe past a deleted slot
    send_request(OP_ADD, 32'h55, '0);         // reuse the deleted slot
    send_request(OP_POP, 32'hffff_ffff, '1);
    send_request(OP_POP, '0, '0);
    send_request(OP_ADD, 32'haaaa_aaaa, 32'h5555_5555);
    send_request(OP_ADD, 32'h5555_5555, 32'haaaa_aaaa);
    send_request(OP_DISCARD, 32'h1, '0);
    send_request(OP_POP, '0, '0);
    send_request(OP_POP, '0, '0);
    send_request(OP_POP, '0, '0);
    send_request(OP_POP, '0, '0);
    drain_results();
  endtask

  // Fill the table to the load limit so that adds are refused.
  task automatic test_fill_limit();
    for (int n = 0; n < 180; n++)
      send_request(OP_ADD, $urandom(), $urandom());
    for (int n = 0; n < 20; n++) random_request(40);
    for (int n = 0; n < 160; n++) send_request(OP_POP, '0, '0);
    drain_results();
  endtask

  // The receiver holds off while requests keep coming.
  task automatic test_back_pressure();
    hold_off_cycles = 300;
    for (int n = 0; n < 20; n++) random_request(50);
    drain_results();
  endtask

  task automatic test_random(input int count, input bit idle);
    send_idling = idle; recv_idling = idle;
    for (int n = 0; n < count; n++) random_request(n % 300 < 150 ? 55 : 20);
    drain_results();
  endtask

  // Receiver side: stall bursts and the long hold-off.
  initial begin
    out_stall <= 1'b1;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (hold_off_cycles > 0) begin
        out_stall <= 1'b1;
        hold_off_cycles--;
      end else if (recv_idling && $urandom_range(4) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 7) - 1) @(posedge clk);
      end else out_stall <= 1'b0;
    end
  end

  // Check each accepted result against the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result", 32'(out_data.status), '0);
      end else begin
        if (out_data.status !== expected_results[0].status)
          report_mismatch("status", 32'(out_data.status), 32'(expected_results[0].status));
        if (out_data.popped_key !== expected_results[0].popped_key)
          report_mismatch("popped_key", out_data.popped_key,
                          expected_results[0].popped_key);
        if (out_data.element_total !== expected_results[0].element_total)
          report_mismatch("element_total", 32'(out_data.element_total),
                          32'(expected_results[0].element_total));
        void'(expected_results.pop_front());
      end
    end
  end

  // Watchdog: count cycles without any transaction.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_data <= '0;
    error_count = 0;
    quiet_cycles = 0;
    hold_off_cycles = 0;
    send_idling = 1; recv_idling = 1;
    mdl_active = 0; mdl_used = 0; mdl_finger = 0;
    for (int s = 0; s < SLOTS; s++) begin
      mdl_tag[s] = TAG_UNUSED; mdl_key[s] = '0; mdl_hash[s] = '0;
    end
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_back_pressure();
    test_fill_limit();
    test_random(650, 1'b1);
    test_random(250, 1'b0);
    repeat (50) @(posedge clk);
    if (error_count == 0 && expected_results.size() == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end
endmodule

[files.f]
sv/oahs_pkg.sv
sv/oahs_ram.sv
sv/oahs_ctrl.sv
sv/oahs_dp.sv
sv/open_addressing_hash_set.sv
tb/testbench.sv
